// ===== hw/rtl/pfrc_pkg.sv =====
package pfrc_pkg;

	localparam int FREQ_W = 16;
	localparam int DIV_EXP_W = 3;
	localparam int MHZ_W = 13;
	localparam int P_W = 18;
	localparam int INT_W = 8;
	localparam int FRAC_W = 10;
	localparam int MOD_W = 10;
	localparam int WORD_W = 32;
	localparam int BEAT_W = 2;

	localparam logic [FREQ_W-1:0] FREQ_MIN = 16'd350;
	localparam logic [FREQ_W-1:0] FREQ_MAX = 16'd44000;
	localparam int MAX_DIV_EXP = 6;
	localparam logic [18:0] VCO_MIN_MHZ = 19'd2200;
	localparam logic [18:0] VCO_MAX_MHZ = 19'd4400;

	// floor(f / 10) as (f * 52429) >> 19, exact for f up to 44000
	localparam logic [15:0] MHZ_RECIP = 16'd52429;
	localparam int MHZ_SHIFT = 19;

	// floor(p / 1000) as (p * 268436) >> 28, exact for p below 2^18
	localparam logic [18:0] RECIP_1000 = 19'd268436;
	localparam int RECIP_1000_SHIFT = 28;
	localparam logic [P_W-1:0] MOD_START = 18'd1000;

	// exact-multiple tests by 5, 25 and 125 on values below 1000
	localparam logic [20:0] RECIP_5 = 21'd205;
	localparam logic [20:0] RECIP_25 = 21'd1311;
	localparam logic [20:0] RECIP_125 = 21'd1049;

	// modulus left after dividing 1000 by 5 zero to three times
	localparam logic [MOD_W-1:0] MOD_BY_G5 [4] = '{10'd1000, 10'd200, 10'd40, 10'd8};

	localparam int QUEUE_AW = 1;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam logic [BEAT_W-1:0] LAST_BEAT = 2'd3;
	localparam logic [WORD_W-1:0] POWER_MASK = 32'h0000_0018;

	typedef enum logic [1:0] {
		CFG_R1_BASE = 2'd0,
		CFG_R4_BASE = 2'd1,
		CFG_RF_OFF  = 2'd2,
		CFG_POWER   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [FREQ_W-1:0]    freq;
		logic [DIV_EXP_W-1:0] div_exp;
	} job_t;

	typedef struct packed {
		logic [WORD_W-1:0] r1_base;
		logic [WORD_W-1:0] r4_base;
		logic [WORD_W-1:0] rf_off;
		logic [1:0]        power;
	} cfg_t;

endpackage

// ===== hw/rtl/pll_frequency_register_calc.sv =====
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  s_tdata[15:0] freq_tenths_mhz
// m_*       out  m_tvalid / m_tready  m_tdata[31:0] reg_word, m_tlast last
// cfg_*     in   cfg_we               cfg_index register, cfg_wdata value
//
// one request gives four output beats: rf-off, r0, r1, r4
// sustained rate is set by the output word serializer and by m_tready stalls
// first word passes the queue, the s1, s2 and s3 registers and the word serializer
// a two-entry queue sits between the classifier and the arithmetic pipeline
// reset clears the config registers to zero and empties queue and pipeline
module pll_frequency_register_calc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] freq_tenths_mhz
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] reg_word
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import pfrc_pkg::*;

	cfg_t cfg_q;
	logic push, push_ready, q_valid, q_pop;
	job_t push_job, q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_R1_BASE: cfg_q.r1_base <= cfg_wdata;
				CFG_R4_BASE: cfg_q.r4_base <= cfg_wdata;
				CFG_RF_OFF:  cfg_q.rf_off <= cfg_wdata;
				CFG_POWER:   cfg_q.power <= cfg_wdata[1:0];
				default: begin
				end
			endcase
		end
	end

	pfrc_front u_front (
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_freq    (s_tdata),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	pfrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_job    (q_job),
		.pop        (q_pop)
	);

	pfrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (q_valid),
		.job       (q_job),
		.job_pop   (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (m_tdata),
		.out_last  (m_tlast)
	);

`ifndef SYNTHESIS
	// a run of four words never breaks off between beats
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("output run broke off before its last beat");

	// the beat after a last beat opens a new run
	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tlast)
		else $error("last flagged on two beats in a row");

	// an accepted request is held in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> q_valid)
		else $error("accepted request missing from queue");
`endif

endmodule

// ===== hw/rtl/pfrc_front.sv =====
module pfrc_front (
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pfrc_pkg::FREQ_W-1:0]       in_freq,
	output logic                              push,
	output pfrc_pkg::job_t                    push_job,
	input  logic                              push_ready
);
	import pfrc_pkg::*;

	logic [FREQ_W-1:0]    freq_c;
	logic [31:0]          mhz_prod;
	logic [MHZ_W-1:0]     mhz;
	logic [DIV_EXP_W-1:0] div_exp;

	always_comb begin
		if (in_freq < FREQ_MIN) begin
			freq_c = FREQ_MIN;
		end else if (in_freq > FREQ_MAX) begin
			freq_c = FREQ_MAX;
		end else begin
			freq_c = in_freq;
		end
	end

	assign mhz_prod = {16'b0, freq_c} * {16'b0, MHZ_RECIP};
	assign mhz = mhz_prod[MHZ_SHIFT +: MHZ_W];

	// smallest exponent that lands the vco in range, largest if none does
	always_comb begin
		logic [18:0] scaled;
		scaled = '0;
		div_exp = DIV_EXP_W'(MAX_DIV_EXP);
		for (int i = MAX_DIV_EXP; i >= 0; i--) begin
			scaled = {6'b0, mhz} << i;
			if (scaled >= VCO_MIN_MHZ && scaled <= VCO_MAX_MHZ) begin
				div_exp = DIV_EXP_W'(i);
			end
		end
	end

	assign in_ready = push_ready;
	assign push = in_valid && push_ready;
	assign push_job.freq = freq_c;
	assign push_job.div_exp = div_exp;

endmodule

// ===== hw/rtl/pfrc_queue.sv =====
module pfrc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfrc_pkg::job_t push_job,
	output logic           push_ready,
	output logic           pop_valid,
	output pfrc_pkg::job_t pop_job,
	input  logic           pop
);
	import pfrc_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = count_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/pfrc_back.sv =====
module pfrc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfrc_pkg::cfg_t                cfg,
	input  logic                          job_valid,
	input  pfrc_pkg::job_t                job,
	output logic                          job_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pfrc_pkg::WORD_W-1:0]   out_word,
	output logic                          out_last
);
	import pfrc_pkg::*;

	// stage 1: vco ratio and integer part
	logic                 v_s1;
	logic [P_W-1:0]       p_s1;
	logic [INT_W-1:0]     int_s1;
	logic [DIV_EXP_W-1:0] k_s1;
	// stage 2: fraction
	logic                 v_s2;
	logic [FRAC_W-1:0]    frac_s2;
	logic [INT_W-1:0]     int_s2;
	logic [DIV_EXP_W-1:0] k_s2;
	// stage 3: factors of five removed
	logic                 v_s3;
	logic [FRAC_W-1:0]    frac5_s3;
	logic [1:0]           g5_s3;
	logic [INT_W-1:0]     int_s3;
	logic [DIV_EXP_W-1:0] k_s3;
	// word serializer
	logic                 busy_q;
	logic [BEAT_W-1:0]    beat_q;
	logic [WORD_W-1:0]    word_q [4];

	logic rdy_s1, rdy_s2, rdy_s3, ser_free;

	assign ser_free = !busy_q || (out_ready && beat_q == LAST_BEAT);
	assign rdy_s3 = !v_s3 || ser_free;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign job_pop = rdy_s1;

	logic [24:0]     p_wide;
	logic [P_W-1:0]  p_c;
	logic [36:0]     int_prod;

	assign p_wide = {7'b0, job.freq, 2'b00} << job.div_exp;
	assign p_c = p_wide[P_W-1:0];
	assign int_prod = {19'b0, p_c} * {18'b0, RECIP_1000};

	logic [P_W-1:0] int_times_mod;
	logic [P_W-1:0] frac_full;

	assign int_times_mod = {10'b0, int_s1} * MOD_START;
	assign frac_full = p_s1 - int_times_mod;

	logic [20:0]       prod5, prod25, prod125;
	logic [1:0]        g5_c;
	logic [FRAC_W-1:0] frac5_c;

	assign prod5 = {11'b0, frac_s2} * RECIP_5;
	assign prod25 = {11'b0, frac_s2} * RECIP_25;
	assign prod125 = {11'b0, frac_s2} * RECIP_125;

	// a multiple leaves a small remainder field after the reciprocal product
	always_comb begin
		if (prod125[16:0] < RECIP_125[16:0]) begin
			g5_c = 2'd3;
			frac5_c = FRAC_W'(prod125[20:17]);
		end else if (prod25[14:0] < RECIP_25[14:0]) begin
			g5_c = 2'd2;
			frac5_c = FRAC_W'(prod25[20:15]);
		end else if (prod5[9:0] < RECIP_5[9:0]) begin
			g5_c = 2'd1;
			frac5_c = FRAC_W'(prod5[20:10]);
		end else begin
			g5_c = 2'd0;
			frac5_c = frac_s2;
		end
	end

	logic [1:0]        g2_c;
	logic [FRAC_W-1:0] frac_r;
	logic [MOD_W-1:0]  mod_r;
	logic [WORD_W-1:0] r0_c, r1_c, r4_c;

	// both still even: at most three factors of two, zero fraction takes all three
	always_comb begin
		if (frac5_s3[0]) begin
			g2_c = 2'd0;
		end else if (frac5_s3[1]) begin
			g2_c = 2'd1;
		end else if (frac5_s3[2]) begin
			g2_c = 2'd2;
		end else begin
			g2_c = 2'd3;
		end
	end

	assign frac_r = frac5_s3 >> g2_c;
	assign mod_r = MOD_BY_G5[g5_s3] >> g2_c;
	assign r0_c = {9'b0, int_s3, 15'b0} + {19'b0, frac_r, 3'b0};
	assign r1_c = cfg.r1_base + {19'b0, mod_r, 3'b0};
	assign r4_c = ((cfg.r4_base & ~POWER_MASK) | {27'b0, cfg.power, 3'b0})
		+ {9'b0, k_s3, 20'b0};

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			p_s1 <= p_c;
			int_s1 <= int_prod[RECIP_1000_SHIFT +: INT_W];
			k_s1 <= job.div_exp;
		end
		if (rdy_s2) begin
			frac_s2 <= frac_full[FRAC_W-1:0];
			int_s2 <= int_s1;
			k_s2 <= k_s1;
		end
		if (rdy_s3) begin
			frac5_s3 <= frac5_c;
			g5_s3 <= g5_c;
			int_s3 <= int_s2;
			k_s3 <= k_s2;
		end
		if (ser_free) begin
			word_q[0] <= cfg.rf_off;
			word_q[1] <= r0_c;
			word_q[2] <= r1_c;
			word_q[3] <= r4_c;
		end else if (out_ready) begin
			word_q[0] <= word_q[1];
			word_q[1] <= word_q[2];
			word_q[2] <= word_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			busy_q <= 1'b0;
			beat_q <= '0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= job_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (ser_free) begin
				busy_q <= v_s3;
				beat_q <= '0;
			end else if (out_ready) begin
				beat_q <= beat_q + 1'b1;
			end
		end
	end

	assign out_valid = busy_q;
	assign out_word = word_q[0];
	assign out_last = busy_q && beat_q == LAST_BEAT;

endmodule

// ===== tb/sv/pll_frequency_register_calc_test.sv =====
`timescale 1ns / 100ps

module pll_frequency_register_calc_test;
	import pfrc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS = 45;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              last;
	} reg_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [FREQ_W-1:0] s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [WORD_W-1:0] m_tdata;
	logic              m_tlast;
	logic              cfg_we = 1'b0;
	cfg_idx_t          cfg_index = CFG_R1_BASE;
	logic [WORD_W-1:0] cfg_wdata = '0;

	// predictor copy of the config registers
	logic [WORD_W-1:0] r1_base = '0;
	logic [WORD_W-1:0] r4_base = '0;
	logic [WORD_W-1:0] rf_off = '0;
	logic [1:0]        power_code = '0;

	reg_beat_t pending_words [$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	bit        source_idling = 1'b1;
	bit        sink_idling = 1'b1;
	int        stall_left = 0;

	pll_frequency_register_calc dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void report_error(input string msg);
		if (mismatch_count < 10)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endfunction

	// four synthesizer words for one requested frequency
	function automatic void predict_reg_words(input logic [FREQ_W-1:0] freq_in);
		logic [FREQ_W-1:0]    f;
		logic [DIV_EXP_W-1:0] div_exp;
		logic [31:0]          vco, p, int_part, frac, modulus;
		bit                   found;
		f = freq_in;
		if (f < FREQ_MIN)
			f = FREQ_MIN;
		if (f > FREQ_MAX)
			f = FREQ_MAX;
		div_exp = DIV_EXP_W'(MAX_DIV_EXP);
		found = 1'b0;
		for (int e = 0; e <= MAX_DIV_EXP; e++) begin
			vco = (32'(f) / 10) << e;
			if (!found && vco >= VCO_MIN_MHZ && vco <= VCO_MAX_MHZ) begin
				div_exp = DIV_EXP_W'(e);
				found = 1'b1;
			end
		end
		p = (32'(f) << div_exp) * 4;
		int_part = p / 1000;
		frac = p % 1000;
		modulus = 1000;
		while (frac % 5 == 0 && modulus % 5 == 0) begin
			frac = frac / 5;
			modulus = modulus / 5;
		end
		while (frac % 2 == 0 && modulus % 2 == 0) begin
			frac = frac / 2;
			modulus = modulus / 2;
		end
		pending_words.push_back('{rf_off, 1'b0});
		pending_words.push_back('{(int_part << 15) + (frac << 3), 1'b0});
		pending_words.push_back('{r1_base + (modulus << 3), 1'b0});
		pending_words.push_back('{((r4_base & ~POWER_MASK) | (32'(power_code) << 3))
			+ (32'(div_exp) << 20), 1'b1});
	endfunction

	function automatic logic [FREQ_W-1:0] random_freq();
		int bound;
		case ($urandom_range(0, 9))
			0: return FREQ_W'($urandom_range(0, 65535));
			1: return FREQ_W'($urandom_range(0, 349));
			2: return FREQ_W'($urandom_range(44001, 65535));
			3: begin
				// land near a divider switch point
				bound = ($urandom_range(0, 1) ? 44000 : 22000) >> $urandom_range(0, MAX_DIV_EXP);
				return FREQ_W'(bound + $urandom_range(0, 40) - 20);
			end
			4: return FREQ_W'($urandom_range(14, 1760) * 25);
			default: return FREQ_W'($urandom_range(350, 44000));
		endcase
	endfunction

	task automatic send_freq(input logic [FREQ_W-1:0] freq);
		int gap;
		gap = (source_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= freq;
		do @(posedge clk); while (!s_tready);
		predict_reg_words(freq);
	endtask

	task automatic wait_all_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_config(input logic [WORD_W-1:0] r1, r4, rf, pwr);
		cfg_idx_t          order [4] = '{CFG_R1_BASE, CFG_R4_BASE, CFG_RF_OFF, CFG_POWER};
		logic [WORD_W-1:0] vals [4];
		vals = '{r1, r4, rf, pwr};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= order[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		r1_base = r1;
		r4_base = r4;
		rf_off = rf;
		power_code = pwr[1:0];
		@(posedge clk);
	endtask

	// runs with the config still at its reset values
	task automatic test_clamp_and_divider();
		logic [FREQ_W-1:0] freqs [16] = '{16'd0, 16'd1, 16'd349, 16'd350, 16'd351, 16'd549,
			16'd550, 16'd4399, 16'd4400, 16'd11000, 16'd21999, 16'd22000, 16'd43999,
			16'd44000, 16'd44001, 16'd65535};
		foreach (freqs[i])
			send_freq(freqs[i]);
		wait_all_done();
	endtask

	// zero fraction, and fractions sharing factors of five and two with the modulus
	task automatic test_fraction_reduction();
		write_config(32'h1234_5678, 32'h0000_0018, 32'hA5A5_5A5A, 32'd2);
		send_freq(16'd25000);
		send_freq(16'd25125);
		send_freq(16'd25001);
		send_freq(16'd25025);
		wait_all_done();
	endtask

	// bases at all ones wrap when the modulus and divider are added, then zero and near-ones bases follow
	task automatic test_config_extremes();
		write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_freq(16'd350);
		send_freq(16'd44000);
		wait_all_done();
		write_config(32'h0, 32'hFFFF_FFE7, 32'h0, 32'hFFFF_FFFC);
		send_freq(16'd1234);
		send_freq(16'd65535);
		wait_all_done();
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				1: write_config('1, '1, '1, 32'd3);
				2: write_config('0, '0, '0, $urandom());
				default: write_config($urandom(), $urandom(), $urandom(), $urandom());
			endcase
			// odd phases run without any idling
			source_idling = (phase % 2 == 0);
			sink_idling = (phase % 2 == 0);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_freq(random_freq());
			wait_all_done();
		end
	endtask

	task automatic test_back_to_back();
		source_idling = 1'b0;
		sink_idling = 1'b0;
		write_config($urandom(), $urandom(), $urandom(), $urandom());
		for (int n = 0; n < 20; n++)
			send_freq(random_freq());
		wait_all_done();
	endtask

	// result checker and sink-side stall generator
	always @(posedge clk) begin
		reg_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				report_error($sformatf("unexpected beat word=%h last=%b", m_tdata, m_tlast));
			end else begin
				want = pending_words.pop_front();
				if (m_tdata !== want.word)
					report_error($sformatf("reg_word expected %h got %h", want.word, m_tdata));
				if (m_tlast !== want.last)
					report_error($sformatf("last expected %b got %b", want.last, m_tlast));
			end
		end
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (arst_n && sink_idling && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("pll_frequency_register_calc regression: fail");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clamp_and_divider();
		test_fraction_reduction();
		test_config_extremes();
		test_random_phases();
		test_back_to_back();
		if (mismatch_count == 0 && pending_words.size() == 0)
			$display("pll_frequency_register_calc regression: pass");
		else
			$display("pll_frequency_register_calc regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/pfrc_pkg.sv
hw/rtl/pfrc_front.sv
hw/rtl/pfrc_queue.sv
hw/rtl/pfrc_back.sv
hw/rtl/pll_frequency_register_calc.sv
tb/sv/pll_frequency_register_calc_test.sv
